@@ src/rmu_pkg.sv @@
// shared types and constants for the recursive mutex unit
package rmu_pkg;

  localparam int REQ_TYPE_W = 2;
  localparam int TASK_W     = 8;
  localparam int STATUS_W   = 3;

  localparam int WAIT_DEPTH_DEF     = 16;
  localparam int MAX_HOLD_DEPTH_DEF = 255;
  localparam int TASK_ID_BITS_DEF   = 8;

  typedef enum logic [REQ_TYPE_W-1:0] {
    REQ_LOCK   = 2'd0,
    REQ_TRY    = 2'd1,
    REQ_UNLOCK = 2'd2
  } req_type_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_GRANTED     = 3'd0,
    ST_WOULD_BLOCK = 3'd1,
    ST_QUEUED      = 3'd2,
    ST_IGNORED     = 3'd3,
    ST_QUEUE_FULL  = 3'd4,
    ST_DEPTH_OVF   = 3'd5
  } mutex_status_t;

endpackage

@@ src/rmu_if.sv @@
// request and response channel interfaces of the recursive mutex unit
interface rmu_req_if import rmu_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [REQ_TYPE_W-1:0] req_type;
  logic [TASK_W-1:0]     requester_task;

  modport source (output valid, output req_type, output requester_task, input ready);
  modport sink   (input valid, input req_type, input requester_task, output ready);
endinterface

interface rmu_rsp_if import rmu_pkg::*;;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                woken_valid;
  logic [TASK_W-1:0]   woken_task;
  logic                held_after;
  logic [TASK_W-1:0]   owner_after;

  modport source (output valid, output status, output woken_valid, output woken_task,
                  output held_after, output owner_after, input ready);
  modport sink   (input valid, input status, input woken_valid, input woken_task,
                  input held_after, input owner_after, output ready);
endinterface

@@ src/recursive_mutex_unit_top.sv @@
// top level of the recursive mutex unit
//
// req channel: one request per handshake carries req_type (lock, try-lock,
// unlock) and requester_task. rsp channel: one response per request with
// status, woken_valid/woken_task for a hand-off on final unlock, and the
// held/owner state after the request.
// A request is taken into an input register, evaluated against the mutex
// state combinationally and written to the response register, from which
// its response is presented. One request per cycle is sustained while
// rsp.ready is high; the waiter stack ram is read at the address of the next
// top entry every cycle so the top is ready for the following request.
// Reset clears the ownership, hold depth, waiter count and both pipeline
// valids; stack entries are not cleared and need no clearing pass.
// When rsp.ready is low the response register holds, the input register
// fills and req.ready then drops until the response is taken.
module recursive_mutex_unit_top import rmu_pkg::*; #(
  parameter int WAIT_DEPTH     = WAIT_DEPTH_DEF,
  parameter int MAX_HOLD_DEPTH = MAX_HOLD_DEPTH_DEF,
  parameter int TASK_ID_BITS   = TASK_ID_BITS_DEF
) (
  input logic      clk,
  input logic      rst,
  rmu_req_if.sink  req,
  rmu_rsp_if.source rsp
);

  localparam int TW = (TASK_ID_BITS < TASK_W) ? TASK_ID_BITS : TASK_W;
  localparam int DW = $clog2(MAX_HOLD_DEPTH + 1);
  localparam int CW = $clog2(WAIT_DEPTH + 1);
  localparam int AW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;

  logic            s1_valid;
  req_type_t       s1_type;
  logic [TW-1:0]   s1_task;

  logic            held, held_next;
  logic [TW-1:0]   owner, owner_next;
  logic [DW-1:0]   depth, depth_next;
  logic [CW-1:0]   count, count_next;
  logic            byp_valid;
  logic [TW-1:0]   byp_data;
  logic [TW-1:0]   ram_rdata;
  logic [TW-1:0]   top;
  logic [AW-1:0]   ram_raddr;
  logic [CW-1:0]   raddr_count;

  logic            push;
  logic            we;
  mutex_status_t   status_c;
  logic            woken_c;
  logic [TW-1:0]   woken_task_c;
  logic            advance;

  logic            o_valid;
  mutex_status_t   o_status;
  logic            o_woken_valid;
  logic [TW-1:0]   o_woken_task;
  logic            o_held;
  logic [TW-1:0]   o_owner;

  assign advance   = s1_valid && (!o_valid || rsp.ready);
  assign req.ready = !s1_valid || advance;
  assign top       = byp_valid ? byp_data : ram_rdata;
  assign we        = push && advance;

  always_comb begin
    held_next    = held;
    owner_next   = owner;
    depth_next   = depth;
    count_next   = count;
    push         = 1'b0;
    status_c     = ST_IGNORED;
    woken_c      = 1'b0;
    woken_task_c = '0;
    case (s1_type)
      REQ_LOCK, REQ_TRY: begin
        if (!held) begin
          held_next  = 1'b1;
          owner_next = s1_task;
          depth_next = DW'(1);
          status_c   = ST_GRANTED;
        end else if (owner == s1_task) begin
          if (depth >= DW'(MAX_HOLD_DEPTH)) begin
            status_c = ST_DEPTH_OVF;
          end else begin
            depth_next = depth + DW'(1);
            status_c   = ST_GRANTED;
          end
        end else if (s1_type == REQ_TRY) begin
          status_c = ST_WOULD_BLOCK;
        end else if (count >= CW'(WAIT_DEPTH)) begin
          status_c = ST_QUEUE_FULL;
        end else begin
          push       = 1'b1;
          count_next = count + CW'(1);
          status_c   = ST_QUEUED;
        end
      end
      REQ_UNLOCK: begin
        if (held && owner == s1_task) begin
          status_c = ST_GRANTED;
          if (depth > DW'(1)) begin
            depth_next = depth - DW'(1);
          end else if (count != '0) begin
            count_next   = count - CW'(1);
            woken_c      = 1'b1;
            woken_task_c = top;
            owner_next   = top;
            depth_next   = DW'(1);
          end else begin
            held_next  = 1'b0;
            owner_next = '0;
            depth_next = '0;
          end
        end
      end
      default: begin
        status_c = ST_IGNORED;
      end
    endcase
  end

  // read address tracks the top entry after this cycle's update
  assign raddr_count = (advance ? count_next : count) - CW'(1);
  assign ram_raddr   = raddr_count[AW-1:0];

  rmu_ram #(
    .WIDTH (TW),
    .DEPTH (WAIT_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (we),
    .waddr (count[AW-1:0]),
    .wdata (s1_task),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      o_valid   <= 1'b0;
      held      <= 1'b0;
      owner     <= '0;
      depth     <= '0;
      count     <= '0;
      byp_valid <= 1'b0;
    end else begin
      if (req.ready) begin
        s1_valid <= req.valid;
      end
      byp_valid <= we;
      if (advance) begin
        o_valid <= 1'b1;
        held    <= held_next;
        owner   <= owner_next;
        depth   <= depth_next;
        count   <= count_next;
      end else if (rsp.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_type <= req_type_t'(req.req_type);
      s1_task <= req.requester_task[TW-1:0];
    end
    byp_data <= s1_task;
    if (advance) begin
      o_status      <= status_c;
      o_woken_valid <= woken_c;
      o_woken_task  <= woken_task_c;
      o_held        <= held_next;
      o_owner       <= held_next ? owner_next : '0;
    end
  end

  assign rsp.valid       = o_valid;
  assign rsp.status      = o_status;
  assign rsp.woken_valid = o_woken_valid;
  assign rsp.woken_task  = TASK_W'(o_woken_task);
  assign rsp.held_after  = o_held;
  assign rsp.owner_after = TASK_W'(o_owner);

endmodule

@@ src/rmu_ram.sv @@
// generic single-write, single-read ram with registered read data
module rmu_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/rmu_checker.sv @@
// port-level checks for the recursive mutex unit and their bind
module rmu_checker import rmu_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input logic [STATUS_W-1:0] status,
  input logic                woken_valid,
  input logic [TASK_W-1:0]   woken_task,
  input logic                held_after,
  input logic [TASK_W-1:0]   owner_after
);

  // a hand-off leaves the woken task as owner
  a_handoff_owner: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && woken_valid |->
      held_after && owner_after == woken_task && status == ST_GRANTED)
    else $error("hand-off response inconsistent");

  // a free mutex reports owner zero
  a_free_owner: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !held_after |-> owner_after == '0)
    else $error("free mutex with nonzero owner");

  // would-block, queued, queue-full and depth-overflow responses imply the mutex stays held
  a_refused_held: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == ST_WOULD_BLOCK || status == ST_QUEUED ||
                  status == ST_QUEUE_FULL || status == ST_DEPTH_OVF) |-> held_after)
    else $error("refused request on a free mutex");

  // stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(owner_after))
    else $error("stalled response changed");

  a_reset_idle: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

endmodule

bind recursive_mutex_unit_top rmu_checker u_rmu_checker (
  .clk         (clk),
  .rst         (rst),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .status      (rsp.status),
  .woken_valid (rsp.woken_valid),
  .woken_task  (rsp.woken_task),
  .held_after  (rsp.held_after),
  .owner_after (rsp.owner_after)
);

@@ tb/sv/tb_top.sv @@
// self-checking testbench for the recursive mutex unit with lifo waiter hand-off
module tb_top;
  import rmu_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int                    WAIT_DEPTH     = WAIT_DEPTH_DEF;
  localparam int                    MAX_HOLD_DEPTH = MAX_HOLD_DEPTH_DEF;
  localparam int                    WATCHDOG_LIMIT = 1000;
  localparam int                    LONG_HOLD      = 80;
  localparam int                    REPORT_LIMIT   = 10;
  localparam logic [REQ_TYPE_W-1:0] REQ_RESERVED   = 2'd3;

  typedef struct packed {
    mutex_status_t     status;
    logic              woken_valid;
    logic [TASK_W-1:0] woken_task;
    logic              held_after;
    logic [TASK_W-1:0] owner_after;
  } mutex_resp_t;

  typedef enum logic [1:0] {
    RX_STEADY,
    RX_RANDOM,
    RX_PATTERN
  } rx_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rmu_req_if req_if ();
  rmu_rsp_if rsp_if ();

  recursive_mutex_unit_top u_top (
    .clk (clk),
    .rst (rst),
    .req (req_if.sink),
    .rsp (rsp_if.source)
  );

  always #5 clk = ~clk;

  // predicted mutex state
  logic              mtx_held;
  logic [TASK_W-1:0] mtx_owner;
  logic [7:0]        mtx_depth;
  logic [TASK_W-1:0] waiter_ids [WAIT_DEPTH];
  int                waiter_cnt;

  mutex_resp_t pending_resps [$];
  logic [TASK_W-1:0] task_pool [5] = '{8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h33};

  int mismatch_count = 0;
  int sent_count     = 0;
  int handoff_count  = 0;
  int peak_waiters   = 0;
  int status_seen [6] = '{default: 0};
  int burst_left     = 0;
  int long_hold_left = 0;
  int idle_cycles    = 0;
  int rx_cycle       = 0;
  rx_mode_t   rx_mode    = RX_STEADY;
  logic [7:0] rx_pattern = 8'b1011_0110;

  function automatic mutex_resp_t predict_request(input logic [REQ_TYPE_W-1:0] rt,
                                                  input logic [TASK_W-1:0] tid);
    mutex_resp_t r;
    logic        owns;
    r = '{status: ST_IGNORED, woken_valid: 1'b0, woken_task: '0,
          held_after: 1'b0, owner_after: '0};
    owns = mtx_held && (mtx_owner == tid);
    if (rt == REQ_LOCK || rt == REQ_TRY) begin
      if (!mtx_held) begin
        mtx_held  = 1'b1;
        mtx_owner = tid;
        mtx_depth = 8'd1;
        r.status  = ST_GRANTED;
      end else if (owns) begin
        if (mtx_depth >= MAX_HOLD_DEPTH) begin
          r.status = ST_DEPTH_OVF;
        end else begin
          mtx_depth = mtx_depth + 8'd1;
          r.status  = ST_GRANTED;
        end
      end else if (rt == REQ_TRY) begin
        r.status = ST_WOULD_BLOCK;
      end else if (waiter_cnt >= WAIT_DEPTH) begin
        r.status = ST_QUEUE_FULL;
      end else begin
        waiter_ids[waiter_cnt] = tid;
        waiter_cnt++;
        r.status = ST_QUEUED;
      end
    end else if (rt == REQ_UNLOCK && owns) begin
      r.status = ST_GRANTED;
      if (mtx_depth > 0) mtx_depth = mtx_depth - 8'd1;
      if (mtx_depth == 0) begin
        if (waiter_cnt > 0) begin
          waiter_cnt--;
          r.woken_valid = 1'b1;
          r.woken_task  = waiter_ids[waiter_cnt];
          mtx_owner     = waiter_ids[waiter_cnt];
          mtx_depth     = 8'd1;
        end else begin
          mtx_held  = 1'b0;
          mtx_owner = '0;
        end
      end
    end
    r.held_after  = mtx_held;
    r.owner_after = mtx_held ? mtx_owner : '0;
    return r;
  endfunction

  task automatic send_request(input logic [REQ_TYPE_W-1:0] rt, input logic [TASK_W-1:0] tid);
    req_if.valid          <= 1'b1;
    req_if.req_type       <= rt;
    req_if.requester_task <= tid;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    pending_resps.push_back(predict_request(rt, tid));
    sent_count++;
    if (waiter_cnt > peak_waiters) peak_waiters = waiter_cnt;
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 10);
    end
  endtask

  task automatic wait_drained;
    req_if.valid <= 1'b0;
    while (pending_resps.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic release_all;
    while (mtx_held) send_request(REQ_UNLOCK, mtx_owner);
  endtask

  task automatic test_basic_ops;
    send_request(REQ_UNLOCK, 8'h00);
    send_request(REQ_RESERVED, 8'hFF);
    send_request(REQ_TRY, 8'h00);
    send_request(REQ_TRY, 8'h00);
    send_request(REQ_LOCK, 8'hFF);
    send_request(REQ_TRY, 8'hFF);
    send_request(REQ_UNLOCK, 8'hFF);
    send_request(REQ_RESERVED, 8'h00);
    send_request(REQ_UNLOCK, 8'h00);
    send_request(REQ_UNLOCK, 8'h00);
    send_request(REQ_LOCK, 8'hAA);
    send_request(REQ_LOCK, 8'h55);
    send_request(REQ_LOCK, 8'hAA);
    send_request(REQ_UNLOCK, 8'hFF);
    send_request(REQ_UNLOCK, 8'hAA);
    send_request(REQ_UNLOCK, 8'h55);
    send_request(REQ_UNLOCK, 8'hAA);
    send_request(REQ_UNLOCK, 8'hAA);
    send_request(REQ_LOCK, 8'h55);
    send_request(REQ_UNLOCK, 8'h55);
  endtask

  task automatic test_waiter_stack_full;
    send_request(REQ_LOCK, 8'h01);
    for (int i = 0; i < WAIT_DEPTH; i++) send_request(REQ_LOCK, 8'h10 + i[7:0]);
    send_request(REQ_LOCK, 8'hF0);
    send_request(REQ_TRY, 8'hF0);
    send_request(REQ_UNLOCK, 8'h10);
    release_all();
  endtask

  task automatic test_hold_depth_limit;
    for (int i = 0; i < MAX_HOLD_DEPTH; i++) send_request(i[0] ? REQ_TRY : REQ_LOCK, 8'h3C);
    send_request(REQ_LOCK, 8'h3C);
    send_request(REQ_TRY, 8'h3C);
    send_request(REQ_LOCK, 8'hC3);
    release_all();
  endtask

  task automatic test_random_traffic(input int n_items);
    logic [REQ_TYPE_W-1:0] rt;
    logic [TASK_W-1:0]     tid;
    int                    pick;
    int                    who;
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 38) rt = REQ_LOCK;
      else if (pick < 58) rt = REQ_TRY;
      else if (pick < 96) rt = REQ_UNLOCK;
      else rt = REQ_RESERVED;
      who = $urandom_range(0, 9);
      if (mtx_held && who < 4) tid = mtx_owner;
      else if (who < 8) tid = task_pool[$urandom_range(0, 4)];
      else tid = TASK_W'($urandom_range(0, 255));
      send_request(rt, tid);
    end
  endtask

  task automatic test_backpressure;
    long_hold_left = LONG_HOLD;
    test_random_traffic(30);
    wait_drained();
  endtask

  // response receiver
  always @(negedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
    end else if (long_hold_left > 0) begin
      rsp_if.ready <= 1'b0;
      long_hold_left--;
    end else begin
      rx_cycle++;
      if (rx_cycle % 97 == 0) rx_mode = rx_mode_t'($urandom_range(0, 2));
      case (rx_mode)
        RX_STEADY: begin
          rsp_if.ready <= 1'b1;
        end
        RX_RANDOM: begin
          rsp_if.ready <= ($urandom_range(0, 3) != 0);
        end
        default: begin
          rsp_if.ready <= rx_pattern[0];
          rx_pattern = {rx_pattern[0], rx_pattern[7:1]};
        end
      endcase
    end
  end

  always @(posedge clk) begin : check_resp
    mutex_resp_t exp_r;
    if (!rst && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (pending_resps.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("%0t: response with no request outstanding: status %0d owner %0h",
                   $realtime, rsp_if.status, rsp_if.owner_after);
      end else begin
        exp_r = pending_resps.pop_front();
        if (rsp_if.status < 6) status_seen[rsp_if.status]++;
        if (rsp_if.woken_valid === 1'b1) handoff_count++;
        if (exp_r.status !== rsp_if.status || exp_r.woken_valid !== rsp_if.woken_valid ||
            exp_r.woken_task !== rsp_if.woken_task || exp_r.held_after !== rsp_if.held_after ||
            exp_r.owner_after !== rsp_if.owner_after) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: exp status %0d woken %b/%0h held %b owner %0h, got %0d %b/%0h %b %0h",
                     $realtime, exp_r.status, exp_r.woken_valid, exp_r.woken_task,
                     exp_r.held_after, exp_r.owner_after, rsp_if.status, rsp_if.woken_valid,
                     rsp_if.woken_task, rsp_if.held_after, rsp_if.owner_after);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no request or response moved for %0d cycles", idle_cycles);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    req_if.valid          = 1'b0;
    req_if.req_type       = REQ_LOCK;
    req_if.requester_task = '0;
    rsp_if.ready          = 1'b0;
    mtx_held              = 1'b0;
    mtx_owner             = '0;
    mtx_depth             = '0;
    waiter_cnt            = 0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_basic_ops();
    test_waiter_stack_full();
    test_hold_depth_limit();
    test_backpressure();
    test_random_traffic(20);

    wait_drained();
    repeat (10) @(negedge clk);
    $display("covered %0d requests: granted %0d, would-block %0d, queued %0d, ignored %0d,",
             sent_count, status_seen[ST_GRANTED], status_seen[ST_WOULD_BLOCK],
             status_seen[ST_QUEUED], status_seen[ST_IGNORED]);
    $display("queue-full %0d, depth-overflow %0d, hand-offs %0d, deepest waiter stack %0d",
             status_seen[ST_QUEUE_FULL], status_seen[ST_DEPTH_OVF], handoff_count, peak_waiters);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/rmu_pkg.sv
src/rmu_if.sv
src/rmu_ram.sv
src/recursive_mutex_unit_top.sv
src/rmu_checker.sv
tb/sv/tb_top.sv
